// ----- src/gan_pkg.sv -----
package gan_pkg;

  localparam int CoordW    = 6;
  localparam int DimW      = 7;
  localparam int CellAw    = 12;
  localparam int OpenDepth = 16384;
  localparam int HeapAw    = 14;
  localparam int CountW    = 15;
  localparam int SeqW      = 15;
  localparam int CostW     = 22;
  localparam int GW        = 21;
  localparam int SqW       = 13;
  localparam int RootW     = 16;
  localparam int InDataW   = 40;
  localparam int OutDataW  = 16;

  localparam logic [DimW-1:0]   GridSide     = 7'd64;
  localparam logic [DimW-1:0]   DimReset     = 7'd64;
  localparam logic [GW-1:0]     StepStraight = 21'd256;
  localparam logic [GW-1:0]     StepDiag     = 21'd362;
  localparam logic [CountW-1:0] CountFull    = 15'(OpenDepth);
  localparam logic [DimW-1:0]   NoMove       = 7'h7f;

  typedef enum logic [1:0] {
    ST_MOVE     = 2'd0,
    ST_AT_GOAL  = 2'd1,
    ST_NO_PATH  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_INIT, S_IDLE, S_CLR, S_HCALC, S_HWAIT, S_PUSH, S_UP_RD, S_UP_CMP, S_AFTER,
    S_POP_RD, S_POP_TAKE, S_DOWN_RD, S_DOWN_CMP, S_CHK_RD, S_CHK_MARK, S_NB_RD,
    S_NB_TEST, S_FIN
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_INIT_CLR, OP_ACCEPT, OP_CLR, OP_HSTART, OP_PUSH, OP_UP_RD, OP_UP_CMP,
    OP_NEXT, OP_POP_RD, OP_POP_TAKE, OP_DOWN_RD, OP_DOWN_CMP, OP_CHK_RD, OP_CHK_MARK,
    OP_NB_RD, OP_EMIT
  } op_e;

  typedef struct packed {
    logic [CostW-1:0]  f;
    logic [GW-1:0]     g;
    logic [SeqW-1:0]   seq;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [1:0]        dir;
  } entry_t;

  typedef struct packed {
    op_e     op;
    status_e status;
  } cmd_t;

  typedef struct packed {
    logic in_search;
    logic in_at_goal;
    logic sweep_last;
    logic diag;
    logic sq_done;
    logic full;
    logic hole_zero;
    logic up_swap;
    logic leaf;
    logic down_swap;
    logic cur_goal;
    logic last_pop;
    logic count_zero;
    logic chk_skip;
    logic nb_valid;
    logic start;
    logic k_last;
    logic out_free;
  } stat_t;

  function automatic logic precedes(entry_t a, entry_t b);
    return {a.f, a.seq} < {b.f, b.seq};
  endfunction

  // neighbor offsets, two's complement on 8 bits
  function automatic logic [7:0] dx_of(logic diag, logic [1:0] k);
    logic [7:0] r;
    if (diag) r = k[0] ? 8'd1 : 8'hff;
    else begin
      case (k)
        2'd2:    r = 8'hff;
        2'd3:    r = 8'd1;
        default: r = 8'd0;
      endcase
    end
    return r;
  endfunction

  function automatic logic [7:0] dy_of(logic diag, logic [1:0] k);
    logic [7:0] r;
    if (diag) r = k[1] ? 8'd1 : 8'hff;
    else begin
      case (k)
        2'd0:    r = 8'hff;
        2'd1:    r = 8'd1;
        default: r = 8'd0;
      endcase
    end
    return r;
  endfunction

endpackage

// ----- src/gan_isqrt.sv -----
module gan_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [gan_pkg::SqW-1:0]   sq_i,
  output logic                      done_o,
  output logic [gan_pkg::RootW-1:0] root_o
);

  logic [29:0] v_q, res_q, bit_q, t;
  logic [3:0]  cnt_q;
  logic        busy_q, done_q, ge;

  assign t  = res_q + bit_q;
  assign ge = v_q >= t;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 4'd1;
      if (cnt_q == 4'd14) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // one result bit per cycle, 15 steps
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= {1'b0, sq_i, 16'd0};
      res_q <= 30'd0;
      bit_q <= 30'd1 << 28;
    end else if (busy_q) begin
      if (ge) begin
        v_q   <= v_q - t;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  // round to nearest when the remainder exceeds the root
  assign root_o = res_q[15:0] + {15'd0, (v_q > res_q)};

endmodule

// ----- src/gan_ctrl.sv -----
module gan_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_tvalid_i,
  output logic            s_tready_o,
  input  gan_pkg::stat_t  stat_i,
  output gan_pkg::cmd_t   cmd_o
);

  gan_pkg::state_e  state_q, state_d;
  gan_pkg::status_e fin_q, fin_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gan_pkg::S_INIT;
      fin_q   <= gan_pkg::ST_MOVE;
    end else begin
      state_q <= state_d;
      fin_q   <= fin_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    fin_d         = fin_q;
    s_tready_o    = 1'b0;
    cmd_o.op      = gan_pkg::OP_NONE;
    cmd_o.status  = fin_q;
    unique case (state_q)
      gan_pkg::S_INIT: begin
        cmd_o.op = gan_pkg::OP_INIT_CLR;
        if (stat_i.sweep_last) state_d = gan_pkg::S_IDLE;
      end
      gan_pkg::S_IDLE: begin
        s_tready_o = 1'b1;
        cmd_o.op   = gan_pkg::OP_ACCEPT;
        if (s_tvalid_i && stat_i.in_search) begin
          if (stat_i.in_at_goal) begin
            fin_d   = gan_pkg::ST_AT_GOAL;
            state_d = gan_pkg::S_FIN;
          end else begin
            state_d = gan_pkg::S_CLR;
          end
        end
      end
      gan_pkg::S_CLR: begin
        cmd_o.op = gan_pkg::OP_CLR;
        if (stat_i.sweep_last) state_d = gan_pkg::S_HCALC;
      end
      gan_pkg::S_HCALC: begin
        cmd_o.op = gan_pkg::OP_HSTART;
        state_d  = stat_i.diag ? gan_pkg::S_HWAIT : gan_pkg::S_PUSH;
      end
      gan_pkg::S_HWAIT: begin
        if (stat_i.sq_done) state_d = gan_pkg::S_PUSH;
      end
      gan_pkg::S_PUSH: begin
        cmd_o.op = gan_pkg::OP_PUSH;
        if (stat_i.full) begin
          fin_d   = gan_pkg::ST_OVERFLOW;
          state_d = gan_pkg::S_FIN;
        end else begin
          state_d = gan_pkg::S_UP_RD;
        end
      end
      gan_pkg::S_UP_RD: begin
        cmd_o.op = gan_pkg::OP_UP_RD;
        state_d  = stat_i.hole_zero ? gan_pkg::S_AFTER : gan_pkg::S_UP_CMP;
      end
      gan_pkg::S_UP_CMP: begin
        cmd_o.op = gan_pkg::OP_UP_CMP;
        state_d  = stat_i.up_swap ? gan_pkg::S_UP_RD : gan_pkg::S_AFTER;
      end
      gan_pkg::S_AFTER: begin
        cmd_o.op = gan_pkg::OP_NEXT;
        state_d  = (stat_i.start || stat_i.k_last) ? gan_pkg::S_POP_RD : gan_pkg::S_NB_RD;
      end
      gan_pkg::S_POP_RD: begin
        cmd_o.op = gan_pkg::OP_POP_RD;
        if (stat_i.count_zero) begin
          fin_d   = gan_pkg::ST_NO_PATH;
          state_d = gan_pkg::S_FIN;
        end else begin
          state_d = gan_pkg::S_POP_TAKE;
        end
      end
      gan_pkg::S_POP_TAKE: begin
        cmd_o.op = gan_pkg::OP_POP_TAKE;
        if (stat_i.cur_goal) begin
          fin_d   = gan_pkg::ST_MOVE;
          state_d = gan_pkg::S_FIN;
        end else if (stat_i.last_pop) begin
          state_d = gan_pkg::S_CHK_RD;
        end else begin
          state_d = gan_pkg::S_DOWN_RD;
        end
      end
      gan_pkg::S_DOWN_RD: begin
        cmd_o.op = gan_pkg::OP_DOWN_RD;
        state_d  = stat_i.leaf ? gan_pkg::S_CHK_RD : gan_pkg::S_DOWN_CMP;
      end
      gan_pkg::S_DOWN_CMP: begin
        cmd_o.op = gan_pkg::OP_DOWN_CMP;
        state_d  = stat_i.down_swap ? gan_pkg::S_DOWN_RD : gan_pkg::S_CHK_RD;
      end
      gan_pkg::S_CHK_RD: begin
        cmd_o.op = gan_pkg::OP_CHK_RD;
        state_d  = gan_pkg::S_CHK_MARK;
      end
      gan_pkg::S_CHK_MARK: begin
        cmd_o.op = gan_pkg::OP_CHK_MARK;
        state_d  = stat_i.chk_skip ? gan_pkg::S_POP_RD : gan_pkg::S_NB_RD;
      end
      gan_pkg::S_NB_RD: begin
        cmd_o.op = gan_pkg::OP_NB_RD;
        state_d  = gan_pkg::S_NB_TEST;
      end
      gan_pkg::S_NB_TEST: begin
        state_d = stat_i.nb_valid ? gan_pkg::S_HCALC : gan_pkg::S_AFTER;
      end
      gan_pkg::S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.op = gan_pkg::OP_EMIT;
          state_d  = gan_pkg::S_IDLE;
        end
      end
      default: state_d = gan_pkg::S_INIT;
    endcase
  end

endmodule

// ----- src/gan_dp.sv -----
module gan_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [gan_pkg::DimW-1:0]     cfg_data_i,
  input  logic                         s_tvalid_i,
  input  logic [gan_pkg::InDataW-1:0]  s_tdata_i,
  input  logic                         s_tuser_i,
  output logic                         m_tvalid_o,
  input  logic                         m_tready_i,
  output logic [gan_pkg::OutDataW-1:0] m_tdata_o,
  input  gan_pkg::cmd_t                cmd_i,
  output gan_pkg::stat_t               stat_o
);

  localparam int CW = gan_pkg::CoordW;

  logic [gan_pkg::DimW-1:0] gw_q, gh_q, ew, eh;
  logic [CW-1:0] sx_q, sy_q, gx_q, gy_q;
  logic          diag_q;

  logic [gan_pkg::CountW-1:0] count_q;
  logic [gan_pkg::SeqW-1:0]   seq_q;
  logic [gan_pkg::CellAw-1:0] clr_q;
  logic                       start_q;
  logic [1:0]                 k_q;
  logic [gan_pkg::HeapAw-1:0] hole_q;
  gan_pkg::entry_t            ins_q, cur_q, rd_a_q, rd_b_q, new_e, child;
  logic [7:0]                 nx_q, ny_q, nx_w, ny_w;

  logic                       m_tvalid_q;
  logic [1:0]                 o_status_q;
  logic [gan_pkg::DimW-1:0]   o_mx_q, o_my_q, fx, fy;
  logic [7:0]                 fdx, fdy;

  gan_pkg::entry_t            heap_mem [gan_pkg::OpenDepth];
  logic                       wall_mem [1 << gan_pkg::CellAw];
  logic                       closed_mem [1 << gan_pkg::CellAw];
  logic                       wall_rd_q, closed_rd_q;

  logic                       hp_we;
  logic [gan_pkg::HeapAw-1:0] hp_wa, ra, rb, pidx;
  gan_pkg::entry_t            hp_wd;

  logic [15:0] l16, r16, cnt16;
  logic        l_ok, r_ok, pick_l, pick_r, up_swap;
  logic [gan_pkg::CellAw-1:0] cur_addr, nb_addr, cl_ra;
  logic        cur_in, nb_in;

  // input beat fields
  logic [CW-1:0] in_cx, in_cy, in_sx, in_sy, in_gx, in_gy;
  logic          in_blk, in_diag;

  logic [CW-1:0]            dxh, dyh;
  logic [11:0]              dx2, dy2;
  logic [gan_pkg::SqW-1:0]  sq;
  logic [14:0]              h_card;
  logic [gan_pkg::RootW-1:0] root, h_w;
  logic                     sq_done, sq_start;
  logic [gan_pkg::GW-1:0]   g_new;

  gan_pkg::op_e op;
  assign op = cmd_i.op;

  assign in_cx   = s_tdata_i[5:0];
  assign in_cy   = s_tdata_i[11:6];
  assign in_blk  = s_tdata_i[12];
  assign in_sx   = s_tdata_i[18:13];
  assign in_sy   = s_tdata_i[24:19];
  assign in_gx   = s_tdata_i[30:25];
  assign in_gy   = s_tdata_i[36:31];
  assign in_diag = s_tdata_i[37];

  assign ew = (gw_q > gan_pkg::GridSide) ? gan_pkg::GridSide : gw_q;
  assign eh = (gh_q > gan_pkg::GridSide) ? gan_pkg::GridSide : gh_q;

  // heuristic of the cell in nx_q / ny_q
  assign dxh    = (nx_q[5:0] > gx_q) ? nx_q[5:0] - gx_q : gx_q - nx_q[5:0];
  assign dyh    = (ny_q[5:0] > gy_q) ? ny_q[5:0] - gy_q : gy_q - ny_q[5:0];
  assign dx2    = 12'(dxh) * 12'(dxh);
  assign dy2    = 12'(dyh) * 12'(dyh);
  assign sq     = {1'b0, dx2} + {1'b0, dy2};
  assign h_card = {({1'b0, dxh} + {1'b0, dyh}), 8'd0};
  assign h_w    = diag_q ? root : {1'b0, h_card};
  assign sq_start = (op == gan_pkg::OP_HSTART) && diag_q;

  gan_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .sq_i    (sq),
    .done_o  (sq_done),
    .root_o  (root)
  );

  assign g_new     = start_q ? '0 :
                     cur_q.g + (diag_q ? gan_pkg::StepDiag : gan_pkg::StepStraight);
  assign new_e.g   = g_new;
  assign new_e.f   = {1'b0, g_new} + gan_pkg::CostW'(h_w);
  assign new_e.seq = seq_q;
  assign new_e.x   = nx_q[5:0];
  assign new_e.y   = ny_q[5:0];
  // children of the start remember their own direction, others inherit it
  assign new_e.dir = (cur_q.seq == '0) ? k_q : cur_q.dir;

  // heap index math
  assign pidx   = (hole_q - 14'd1) >> 1;
  assign l16    = {1'b0, hole_q, 1'b1};
  assign r16    = l16 + 16'd1;
  assign cnt16  = {1'b0, count_q};
  assign l_ok   = l16 < cnt16;
  assign r_ok   = r16 < cnt16;
  assign pick_l = l_ok && gan_pkg::precedes(rd_a_q, ins_q);
  assign pick_r = r_ok && gan_pkg::precedes(rd_b_q, pick_l ? rd_a_q : ins_q);
  assign child  = pick_r ? rd_b_q : rd_a_q;
  assign up_swap = gan_pkg::precedes(ins_q, rd_a_q);

  always_comb begin
    hp_we = 1'b0;
    hp_wa = hole_q;
    hp_wd = ins_q;
    ra    = pidx;
    rb    = r16[13:0];
    case (op)
      gan_pkg::OP_UP_RD: hp_we = (hole_q == '0);
      gan_pkg::OP_UP_CMP: begin
        hp_we = 1'b1;
        if (up_swap) hp_wd = rd_a_q;
      end
      gan_pkg::OP_POP_RD: begin
        ra = '0;
        rb = count_q[13:0] - 14'd1;
      end
      gan_pkg::OP_DOWN_RD: begin
        ra    = l16[13:0];
        hp_we = !l_ok;
      end
      gan_pkg::OP_DOWN_CMP: begin
        hp_we = 1'b1;
        if (pick_l || pick_r) hp_wd = child;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (hp_we) heap_mem[hp_wa] <= hp_wd;
    rd_a_q <= heap_mem[ra];
    rd_b_q <= heap_mem[rb];
  end

  // cell addresses
  assign nx_w     = {2'b00, cur_q.x} + gan_pkg::dx_of(diag_q, k_q);
  assign ny_w     = {2'b00, cur_q.y} + gan_pkg::dy_of(diag_q, k_q);
  assign cur_addr = {cur_q.y, cur_q.x};
  assign nb_addr  = {ny_w[5:0], nx_w[5:0]};
  assign cl_ra    = (op == gan_pkg::OP_CHK_RD) ? cur_addr : nb_addr;
  assign cur_in   = ({1'b0, cur_q.x} < ew) && ({1'b0, cur_q.y} < eh);
  assign nb_in    = !nx_q[7] && !ny_q[7] && (nx_q[6:0] < ew) && (ny_q[6:0] < eh);

  always_ff @(posedge clk_i) begin
    if (op == gan_pkg::OP_INIT_CLR) wall_mem[clr_q] <= 1'b0;
    else if (op == gan_pkg::OP_ACCEPT && s_tvalid_i && !s_tuser_i)
      wall_mem[{in_cy, in_cx}] <= in_blk;
    wall_rd_q <= wall_mem[nb_addr];
  end

  always_ff @(posedge clk_i) begin
    if (op == gan_pkg::OP_CLR) closed_mem[clr_q] <= 1'b0;
    else if (op == gan_pkg::OP_CHK_MARK && !(cur_in && closed_rd_q) && cur_in)
      closed_mem[cur_addr] <= 1'b1;
    closed_rd_q <= closed_mem[cl_ra];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gw_q       <= gan_pkg::DimReset;
      gh_q       <= gan_pkg::DimReset;
      count_q    <= '0;
      seq_q      <= '0;
      clr_q      <= '0;
      start_q    <= 1'b0;
      k_q        <= 2'd0;
      m_tvalid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i) gh_q <= cfg_data_i;
        else           gw_q <= cfg_data_i;
      end
      if (op == gan_pkg::OP_EMIT)  m_tvalid_q <= 1'b1;
      else if (m_tready_i)         m_tvalid_q <= 1'b0;
      case (op)
        gan_pkg::OP_INIT_CLR: clr_q <= clr_q + 12'd1;
        gan_pkg::OP_CLR: begin
          clr_q <= clr_q + 12'd1;
          if (clr_q == '1) begin
            count_q <= '0;
            seq_q   <= '0;
            start_q <= 1'b1;
          end
        end
        gan_pkg::OP_PUSH: begin
          if (count_q != gan_pkg::CountFull) begin
            count_q <= count_q + 15'd1;
            seq_q   <= seq_q + 15'd1;
          end
        end
        gan_pkg::OP_NEXT: begin
          start_q <= 1'b0;
          k_q     <= k_q + 2'd1;
        end
        gan_pkg::OP_POP_TAKE: count_q <= count_q - 15'd1;
        gan_pkg::OP_CHK_MARK: k_q <= 2'd0;
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    case (op)
      gan_pkg::OP_ACCEPT: begin
        if (s_tvalid_i && s_tuser_i) begin
          sx_q   <= in_sx;
          sy_q   <= in_sy;
          gx_q   <= in_gx;
          gy_q   <= in_gy;
          diag_q <= in_diag;
        end
      end
      gan_pkg::OP_CLR: begin
        nx_q <= {2'b00, sx_q};
        ny_q <= {2'b00, sy_q};
      end
      gan_pkg::OP_PUSH: begin
        ins_q  <= new_e;
        hole_q <= count_q[13:0];
      end
      gan_pkg::OP_UP_CMP:   if (up_swap) hole_q <= pidx;
      gan_pkg::OP_POP_TAKE: begin
        cur_q  <= rd_a_q;
        ins_q  <= rd_b_q;
        hole_q <= '0;
      end
      gan_pkg::OP_DOWN_CMP: if (pick_l || pick_r) hole_q <= pick_r ? r16[13:0] : l16[13:0];
      gan_pkg::OP_NB_RD: begin
        nx_q <= nx_w;
        ny_q <= ny_w;
      end
      gan_pkg::OP_EMIT: begin
        o_status_q <= cmd_i.status;
        case (cmd_i.status)
          gan_pkg::ST_MOVE: begin
            o_mx_q <= fx;
            o_my_q <= fy;
          end
          gan_pkg::ST_AT_GOAL: begin
            o_mx_q <= {1'b0, sx_q};
            o_my_q <= {1'b0, sy_q};
          end
          default: begin
            o_mx_q <= gan_pkg::NoMove;
            o_my_q <= gan_pkg::NoMove;
          end
        endcase
      end
      default: ;
    endcase
  end

  assign fdx = gan_pkg::dx_of(diag_q, cur_q.dir);
  assign fdy = gan_pkg::dy_of(diag_q, cur_q.dir);
  assign fx  = {1'b0, sx_q} + fdx[6:0];
  assign fy  = {1'b0, sy_q} + fdy[6:0];

  assign m_tvalid_o = m_tvalid_q;
  assign m_tdata_o  = {o_my_q, o_mx_q, o_status_q};

  always_comb begin
    stat_o.in_search  = s_tuser_i;
    stat_o.in_at_goal = (in_sx == in_gx) && (in_sy == in_gy);
    stat_o.sweep_last = (clr_q == '1);
    stat_o.diag       = diag_q;
    stat_o.sq_done    = sq_done;
    stat_o.full       = (count_q == gan_pkg::CountFull);
    stat_o.hole_zero  = (hole_q == '0);
    stat_o.up_swap    = up_swap;
    stat_o.leaf       = !l_ok;
    stat_o.down_swap  = pick_l || pick_r;
    stat_o.cur_goal   = (rd_a_q.x == gx_q) && (rd_a_q.y == gy_q);
    stat_o.last_pop   = (count_q == 15'd1);
    stat_o.count_zero = (count_q == '0);
    stat_o.chk_skip   = cur_in && closed_rd_q;
    stat_o.nb_valid   = nb_in && !wall_rd_q && !closed_rd_q;
    stat_o.start      = start_q;
    stat_o.k_last     = (k_q == 2'd3);
    stat_o.out_free   = !m_tvalid_q || m_tready_i;
  end

endmodule

// ----- src/grid_astar_next_move.sv -----
// Grid A* next-move engine.
// Input stream: tuser is the item kind (0 map write, 1 search). A map write
// stores one cell of the 64x64 wall map. A search runs A* from start to goal
// and produces one output beat: status, then move_x and move_y of the first
// step (start cell when already at goal, -1 on no path or heap overflow).
// Config port: cfg_idx_i 0 writes grid width, 1 writes grid height; write only
// while idle.
// After reset the wall map is cleared with tready low.
// A search whose start is its goal answers without running A*. Any other
// search first clears the closed marks, then each expansion pops the heap
// (sifting down), checks the closed mark, reads the neighbors and pushes each
// valid one with a sift-up; in diagonal mode each pushed neighbor first waits
// for the bit-serial square root. The heap memory port and the one-at-a-time
// sequencer set the pace of a search.
// Only one item is in flight. A finished result sits in the output register;
// new input is accepted while it waits, but a later search cannot deliver its
// result until the receiver has taken the earlier beat.
module grid_astar_next_move (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [gan_pkg::DimW-1:0]     cfg_data_i,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // cell_x, cell_y, cell_blocked, start_x, start_y, goal_x, goal_y, diagonal
  input  logic [gan_pkg::InDataW-1:0]  s_axis_tdata_i,
  // kind
  input  logic                         s_axis_tuser_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // status, move_x, move_y
  output logic [gan_pkg::OutDataW-1:0] m_axis_tdata_o
);

  gan_pkg::cmd_t  cmd;
  gan_pkg::stat_t stat;

  gan_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gan_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tdata_i  (s_axis_tdata_i),
    .s_tuser_i  (s_axis_tuser_i),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .m_tdata_o  (m_axis_tdata_o),
    .cmd_i      (cmd),
    .stat_o     (stat)
  );

endmodule
